/* src/clnqw_pkg.sv */
`timescale 1ns / 1ps

package clnqw_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BUSY = 2'd2;

   // Request kinds: a push offers one byte, a tick advances time by one step.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_POWER_WAIT = 2'd0;
   localparam logic [1:0] REG_STEP_WAIT  = 2'd1;
   localparam logic [1:0] REG_FINAL_WAIT = 2'd2;

   // Register reset values.
   localparam logic [7:0] POWER_WAIT_RESET = 8'd50;
   localparam logic [7:0] STEP_WAIT_RESET  = 8'd5;
   localparam logic [7:0] FINAL_WAIT_RESET = 8'd3;

   // Init nibbles and the number of nibbles in the setup command list.
   localparam logic [3:0] INIT_NIBBLE_WAKE = 4'h3;
   localparam logic [3:0] INIT_NIBBLE_4BIT = 4'h2;
   localparam logic [3:0] SETUP_NIBBLES    = 4'd10;

   // One queue command: a push of a whole byte plus its command mark, or a pop.
   typedef struct packed {
      logic       push;
      logic       push_mark;
      logic [7:0] push_byte;
      logic       pop;
   } queue_cmd_type;

   // One nibble as it leaves the queue.
   typedef struct packed {
      logic       mark;
      logic [3:0] nibble;
   } queue_entry_type;

   // Setup commands 0x28, 0x08, 0x01, 0x06, 0x0C, high nibble first.
   function automatic logic [3:0] setup_nibble(input logic [3:0] idx);
      logic [3:0] nib;
      case (idx)
         4'd0:    nib = 4'h2;
         4'd1:    nib = 4'h8;
         4'd2:    nib = 4'h0;
         4'd3:    nib = 4'h8;
         4'd4:    nib = 4'h0;
         4'd5:    nib = 4'h1;
         4'd6:    nib = 4'h0;
         4'd7:    nib = 4'h6;
         4'd8:    nib = 4'h0;
         4'd9:    nib = 4'hC;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

/* src/clnqw_queue.sv */
`timescale 1ns / 1ps

module clnqw_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  clnqw_pkg::queue_cmd_type              cmd,
   output logic [$clog2(QUEUE_DEPTH + 1) - 1:0]  level,
   output clnqw_pkg::queue_entry_type            head
);
   import clnqw_pkg::*;

   localparam int SLOTS = QUEUE_DEPTH / 2;
   localparam int PTR_W = $clog2(SLOTS);
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

   // Each slot stores a pushed byte with its mark, so a push is one write.
   logic [8:0]       pair_mem [SLOTS];
   logic [8:0]       pair_rd_ff;
   logic             rd_sel_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rd_half_ff, rd_half_in;
   logic [LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_half_in = rd_half_ff;
      level_in   = level_ff;
      if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         level_in  = level_ff + LVL_W'(2);
      end else if (cmd.pop) begin
         rd_half_in = ~rd_half_ff;
         if (rd_half_ff) begin
            rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         rd_half_ff <= 1'b0;
         level_ff   <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         rd_half_ff <= rd_half_in;
         level_ff   <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pair_mem[wr_ptr_ff] <= {cmd.push_mark, cmd.push_byte};
      end
      if (cmd.pop) begin
         pair_rd_ff <= pair_mem[rd_ptr_ff];
         rd_sel_ff  <= rd_half_ff;
      end
   end

   assign level       = level_ff;
   assign head.mark   = pair_rd_ff[8];
   assign head.nibble = rd_sel_ff ? pair_rd_ff[3:0] : pair_rd_ff[7:4];

endmodule

/* src/char_lcd_nibble_queue_writer_unit.sv */
`timescale 1ns / 1ps

// Character LCD writer for a 4-bit bus with a nibble queue.
//
// Requests arrive on the req_ channel: a push (req_mode 0) offers one byte with its
// command flag, a tick (req_mode 1) advances time by one step. Every request gives
// exactly one response on the rsp_ channel with the pin levels (nibble and RS), the
// enable strobe, a drop status and the init-done flag.
//
// The request updates the control state and issues the queue memory read at its
// accepting edge, and the response register is loaded as the request leaves the
// middle stage. Throughput is one request per cycle while the receiver does not
// stall; the only loop is the control state update, a read-modify-write of the
// pointers, and the queue memory has one write and one registered read port.
//
// After reset the power-up sequence waits power_wait ticks, then sends three 0x3
// nibbles and one 0x2 nibble, and finally makes the five setup commands available
// ahead of any pushed byte. The queue memory needs no clearing pass. When the
// receiver stalls, one response waits in the output register and a second one in
// the stage before it; the request side stalls only when both are occupied.

module char_lcd_nibble_queue_writer_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_byte_in,
   input  logic        req_is_command,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_lcd_nibble,
   output logic        rsp_lcd_rs,
   output logic        rsp_enable_strobe,
   output logic [1:0]  rsp_status,
   output logic        rsp_init_done,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import clnqw_pkg::*;

   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   // Init phases: zero to two await a 0x3 nibble.
   localparam logic [2:0] PHASE_POWER_WAIT = 3'd0;
   localparam logic [2:0] PHASE_FUNC_SET   = 3'd3;
   localparam logic [2:0] PHASE_FINAL_WAIT = 3'd4;
   localparam logic [2:0] PHASE_DONE       = 3'd5;

   // How the held pins change when a request leaves the middle stage.
   localparam logic [1:0] PIN_HOLD  = 2'd0;
   localparam logic [1:0] PIN_LOAD  = 2'd1;
   localparam logic [1:0] PIN_QUEUE = 2'd2;

   typedef struct packed {
      logic [1:0] pin_sel;
      logic [4:0] pins;       // RS in bit 4, nibble below.
      logic       strobe;
      logic [1:0] status;
      logic       init_done;
   } stage_type;

   // Registers.
   logic [7:0] power_wait_ff, power_wait_in;
   logic [7:0] step_wait_ff, step_wait_in;
   logic [7:0] final_wait_ff, final_wait_in;
   logic [7:0] wait_ff, wait_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] setup_left_ff, setup_left_in;
   logic [4:0] held_ff, held_in;

   logic       s1_valid_ff;
   stage_type  s1_ff, s1_in;

   logic       rsp_valid_ff;
   logic [4:0] rsp_pins_ff;
   logic       rsp_strobe_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_done_ff;

   // Handshake and queue signals.
   logic            accept;
   logic            s1_advance;
   logic            cfg_write;
   logic [7:0]      wait_dec;
   logic [LVL_W:0]  total_level;
   logic [LVL_W-1:0] q_level;
   queue_cmd_type   q_cmd;
   queue_entry_type q_head;

   // The middle stage moves on whenever the output register is free or drains now.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign cfg_write  = psel && penable && pwrite;
   assign pready     = 1'b1;

   always_comb begin
      case (paddr[3:2])
         REG_POWER_WAIT: prdata = {24'd0, power_wait_ff};
         REG_STEP_WAIT:  prdata = {24'd0, step_wait_ff};
         REG_FINAL_WAIT: prdata = {24'd0, final_wait_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // The setup nibbles count as queued entries ahead of the memory contents.
   assign total_level = (LVL_W + 1)'(q_level) + (LVL_W + 1)'(setup_left_ff);
   assign wait_dec    = (wait_ff != 8'd0) ? wait_ff - 8'd1 : wait_ff;

   always_comb begin
      power_wait_in = power_wait_ff;
      step_wait_in  = step_wait_ff;
      final_wait_in = final_wait_ff;
      wait_in       = wait_ff;
      phase_in      = phase_ff;
      setup_left_in = setup_left_ff;

      q_cmd.push      = 1'b0;
      q_cmd.push_mark = req_is_command;
      q_cmd.push_byte = req_byte_in;
      q_cmd.pop       = 1'b0;

      s1_in.pin_sel   = PIN_HOLD;
      s1_in.pins      = 5'd0;
      s1_in.strobe    = 1'b0;
      s1_in.status    = STATUS_OK;
      s1_in.init_done = 1'b0;

      // Register writes are for the user to make only while the block is idle; the block does not enforce it.
      if (cfg_write) begin
         case (paddr[3:2])
            REG_POWER_WAIT: begin
               power_wait_in = pwdata[7:0];
               if (phase_ff == PHASE_POWER_WAIT) begin
                  wait_in = pwdata[7:0];
               end
            end
            REG_STEP_WAIT:  step_wait_in  = pwdata[7:0];
            REG_FINAL_WAIT: final_wait_in = pwdata[7:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (req_mode == MODE_PUSH) begin
            if (phase_ff != PHASE_DONE) begin
               s1_in.status = STATUS_BUSY;
            end else if (total_level > (LVL_W + 1)'(QUEUE_DEPTH - 2)) begin
               s1_in.status = STATUS_FULL;
            end else begin
               q_cmd.push = 1'b1;
            end
         end else begin
            wait_in = wait_dec;
            if (phase_ff != PHASE_DONE) begin
               if (wait_dec == 8'd0) begin
                  case (phase_ff)
                     PHASE_FUNC_SET: begin
                        s1_in.pin_sel = PIN_LOAD;
                        s1_in.pins    = {1'b0, INIT_NIBBLE_4BIT};
                        s1_in.strobe  = 1'b1;
                        wait_in       = final_wait_ff;
                        phase_in      = PHASE_FINAL_WAIT;
                     end
                     PHASE_FINAL_WAIT: begin
                        setup_left_in = SETUP_NIBBLES;
                        phase_in      = PHASE_DONE;
                     end
                     default: begin
                        s1_in.pin_sel = PIN_LOAD;
                        s1_in.pins    = {1'b0, INIT_NIBBLE_WAKE};
                        s1_in.strobe  = 1'b1;
                        wait_in       = step_wait_ff;
                        phase_in      = phase_ff + 3'd1;
                     end
                  endcase
               end
            end else if (setup_left_ff != 4'd0) begin
               s1_in.pin_sel = PIN_LOAD;
               s1_in.pins    = {1'b0, setup_nibble(SETUP_NIBBLES - setup_left_ff)};
               s1_in.strobe  = 1'b1;
               setup_left_in = setup_left_ff - 4'd1;
            end else if (q_level != '0) begin
               s1_in.pin_sel = PIN_QUEUE;
               s1_in.strobe  = 1'b1;
               q_cmd.pop     = 1'b1;
            end
         end
         s1_in.init_done = (phase_in == PHASE_DONE);
      end
   end

   // The pins change in request order, as each request leaves the middle stage.
   always_comb begin
      case (s1_ff.pin_sel)
         PIN_LOAD:  held_in = s1_ff.pins;
         PIN_QUEUE: held_in = {~q_head.mark, q_head.nibble};
         default:   held_in = held_ff;
      endcase
   end

   clnqw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .level (q_level),
      .head  (q_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         power_wait_ff <= POWER_WAIT_RESET;
         step_wait_ff  <= STEP_WAIT_RESET;
         final_wait_ff <= FINAL_WAIT_RESET;
         wait_ff       <= POWER_WAIT_RESET;
         phase_ff      <= PHASE_POWER_WAIT;
         setup_left_ff <= 4'd0;
         held_ff       <= 5'd0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         power_wait_ff <= power_wait_in;
         step_wait_ff  <= step_wait_in;
         final_wait_ff <= final_wait_in;
         wait_ff       <= wait_in;
         phase_ff      <= phase_in;
         setup_left_ff <= setup_left_in;
         if (s1_advance) begin
            held_ff <= held_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_advance) begin
         rsp_pins_ff   <= held_in;
         rsp_strobe_ff <= s1_ff.strobe;
         rsp_status_ff <= s1_ff.status;
         rsp_done_ff   <= s1_ff.init_done;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lcd_nibble    = rsp_pins_ff[3:0];
   assign rsp_lcd_rs        = rsp_pins_ff[4];
   assign rsp_enable_strobe = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_init_done     = rsp_done_ff;

endmodule

/* src/clnqw_checker.sv */
`timescale 1ns / 1ps

module clnqw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_lcd_nibble,
   input logic       rsp_lcd_rs,
   input logic       rsp_enable_strobe,
   input logic [1:0] rsp_status,
   input logic       rsp_init_done
);
   import clnqw_pkg::*;

   logic seen_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_init_done) begin
         seen_done_ff <= 1'b1;
      end
   end

   // Once the setup is reported done it stays done until reset.
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_done_ff |-> rsp_init_done)
      else $error("init_done fell after it was reported");

   // A dropped push never strobes the display.
   a_drop_no_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> !rsp_enable_strobe)
      else $error("strobe on a dropped push");

   // Busy drops only happen before setup is done, full drops only after.
   a_drop_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_BUSY) && !rsp_init_done) ||
                    ((rsp_status == STATUS_FULL) && rsp_init_done) ||
                    (rsp_status == STATUS_OK))
      else $error("status code does not match the init state");

   // During power-up only the wake and 4-bit nibbles go out, as commands.
   a_init_nibbles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_strobe && !rsp_init_done |->
         !rsp_lcd_rs && ((rsp_lcd_nibble == INIT_NIBBLE_WAKE) ||
                         (rsp_lcd_nibble == INIT_NIBBLE_4BIT)))
      else $error("unexpected nibble during power-up");

endmodule

bind char_lcd_nibble_queue_writer_unit clnqw_checker u_clnqw_checker (.*);
